FILE: src/vfcm_pkg.sv
// Shared types and constants for the voxel face culling and occlusion mesher.
// Depends on nothing; used by vfcm_ctrl, vfcm_datapath and the top level.
`timescale 1ns / 1ps
package vfcm_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Configuration register indexes
    localparam logic [3:0] REG_OPQ0 = 4'd0;
    localparam logic [3:0] REG_OPQ1 = 4'd1;
    localparam logic [3:0] REG_OPQ2 = 4'd2;
    localparam logic [3:0] REG_OPQ3 = 4'd3;
    localparam logic [3:0] REG_SEE0 = 4'd4;
    localparam logic [3:0] REG_SEE1 = 4'd5;
    localparam logic [3:0] REG_SEE2 = 4'd6;
    localparam logic [3:0] REG_SEE3 = 4'd7;

    // Actions
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_MESH  = 1'b1;

    // Neighbourhood slot numbers, slot = (dx+1)*9 + (dy+1)*3 + (dz+1)
    localparam logic [4:0] K_CENTRE = 5'd13;
    localparam logic [4:0] K_TOP    = 5'd16;
    localparam logic [4:0] K_BOTTOM = 5'd10;
    localparam logic [4:0] K_PZ     = 5'd14;
    localparam logic [4:0] K_MZ     = 5'd12;
    localparam logic [4:0] K_MX     = 5'd4;
    localparam logic [4:0] K_PX     = 5'd22;

    localparam logic [2:0] FACE_LAST = 3'd5;

    // Read source for a neighbourhood slot
    localparam logic [1:0] SRC_MEM   = 2'd0;
    localparam logic [1:0] SRC_SOLID = 2'd1;
    localparam logic [1:0] SRC_AIR   = 2'd2;

    // Corner offsets: [face][corner][side1, side2, corner][dx, dy, dz]
    localparam int CORNER_OFS [6][4][3][3] = '{
        '{ '{'{-1,1,0},'{0,1,-1},'{-1,1,-1}}, '{'{-1,1,0},'{0,1,1},'{-1,1,1}},
           '{'{1,1,0},'{0,1,1},'{1,1,1}},     '{'{1,1,0},'{0,1,-1},'{1,1,-1}} },
        '{ '{'{-1,-1,0},'{0,-1,-1},'{-1,-1,-1}}, '{'{1,-1,0},'{0,-1,-1},'{1,-1,-1}},
           '{'{1,-1,0},'{0,-1,1},'{1,-1,1}},     '{'{-1,-1,0},'{0,-1,1},'{-1,-1,1}} },
        '{ '{'{-1,0,1},'{0,-1,1},'{-1,-1,1}}, '{'{1,0,1},'{0,-1,1},'{1,-1,1}},
           '{'{1,0,1},'{0,1,1},'{1,1,1}},     '{'{-1,0,1},'{0,1,1},'{-1,1,1}} },
        '{ '{'{1,0,-1},'{0,-1,-1},'{1,-1,-1}}, '{'{-1,0,-1},'{0,-1,-1},'{-1,-1,-1}},
           '{'{-1,0,-1},'{0,1,-1},'{-1,1,-1}}, '{'{1,0,-1},'{0,1,-1},'{1,1,-1}} },
        '{ '{'{-1,-1,0},'{-1,0,-1},'{-1,-1,-1}}, '{'{-1,-1,0},'{-1,0,1},'{-1,-1,1}},
           '{'{-1,1,0},'{-1,0,1},'{-1,1,1}},     '{'{-1,1,0},'{-1,0,-1},'{-1,1,-1}} },
        '{ '{'{1,-1,0},'{1,0,1},'{1,-1,1}},  '{'{1,-1,0},'{1,0,-1},'{1,-1,-1}},
           '{'{1,1,0},'{1,0,-1},'{1,1,-1}},  '{'{1,1,0},'{1,0,1},'{1,1,1}} }
    };

    // Slot number of one side or corner voxel of a face corner
    function automatic logic [4:0] corner_slot(logic [2:0] f, logic [1:0] c, logic [1:0] s);
        int v;
        v = (CORNER_OFS[f][c][s][0] + 1) * 9 + (CORNER_OFS[f][c][s][1] + 1) * 3
          + (CORNER_OFS[f][c][s][2] + 1);
        return 5'(v);
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic       start;    // latch coordinate, clear read digits
        logic       store;    // write the store item
        logic       rd_adv;   // issue one neighbourhood read
        logic       emit;     // load the output register with the current face
        logic [2:0] face;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       rd_last;
        logic       out_free;
        logic [5:0] vis;
    } t_sts;

endpackage

FILE: src/voxel_face_cull_ao_mesher.sv
// Top level of the voxel face culling and occlusion mesher.
// Depends on vfcm_pkg, vfcm_ctrl and vfcm_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | i_valid / o_ready    | i_action, i_pos_x/y/z, i_block_value
//   result   | o_valid / i_ready    | o_face_x/y/z, o_face_dir, o_occl_0..3,
//            |                      | o_face_block, o_see_through, o_last_face
//   config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A store transaction is written from the idle state. A mesh transaction makes 27
// reads of the voxel store, passes a drain state, then walks the six faces in order.
// A stalled result holds the face walk until the output frees.
// Synchronous active-low reset clears the masks and control; the store is not
// cleared.
`timescale 1ns / 1ps
module voxel_face_cull_ao_mesher #(
    parameter int SIDE_LEN      = 16,
    parameter int COLUMN_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [3:0]  i_pos_x,
    input  logic [6:0]  i_pos_y,
    input  logic [3:0]  i_pos_z,
    input  logic [7:0]  i_block_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_face_x,
    output logic [6:0]  o_face_y,
    output logic [3:0]  o_face_z,
    output logic [2:0]  o_face_dir,
    output logic [1:0]  o_occl_0,
    output logic [1:0]  o_occl_1,
    output logic [1:0]  o_occl_2,
    output logic [1:0]  o_occl_3,
    output logic [7:0]  o_face_block,
    output logic        o_see_through,
    output logic        o_last_face
);
    import vfcm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_range;

    // Drop coordinates beyond the chunk
    assign in_range = (int'(i_pos_x) < SIDE_LEN) && (int'(i_pos_z) < SIDE_LEN)
                   && (int'(i_pos_y) < COLUMN_HEIGHT);

    vfcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_in_range (in_range),
        .o_ready    (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vfcm_datapath #(
        .SIDE_LEN      (SIDE_LEN),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_block_value (i_block_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_face_x      (o_face_x),
        .o_face_y      (o_face_y),
        .o_face_z      (o_face_z),
        .o_face_dir    (o_face_dir),
        .o_occl_0      (o_occl_0),
        .o_occl_1      (o_occl_1),
        .o_occl_2      (o_occl_2),
        .o_occl_3      (o_occl_3),
        .o_face_block  (o_face_block),
        .o_see_through (o_see_through),
        .o_last_face   (o_last_face)
    );

endmodule

FILE: src/vfcm_ctrl.sv
// Controller state machine of the mesher: read sweep, drain and face emission.
// Depends on vfcm_pkg.
`timescale 1ns / 1ps
module vfcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_action,
    input  logic            i_in_range,
    output logic            o_ready,
    input  vfcm_pkg::t_sts  i_sts,
    output vfcm_pkg::t_cmd  o_cmd
);
    import vfcm_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_face, n_face;

    // State and face counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_face  <= '0;
        end else begin
            r_state <= n_state;
            r_face  <= n_face;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_face      = r_face;
        o_ready     = 1'b0;
        o_cmd       = '0;
        o_cmd.face  = r_face;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_in_range) begin
                    if (i_action == ACT_STORE) begin
                        o_cmd.store = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_adv = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_face  = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // skip hidden faces, hold a visible one until the output frees
                if (!i_sts.vis[r_face] || i_sts.out_free) begin
                    o_cmd.emit = i_sts.vis[r_face];
                    n_face     = r_face + 3'd1;
                    if (r_face == FACE_LAST) begin
                        n_face  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/vfcm_datapath.sv
// Datapath of the mesher: voxel store, neighbourhood capture, culling, occlusion,
// mask registers and output register. Depends on vfcm_pkg.
`timescale 1ns / 1ps
module vfcm_datapath #(
    parameter int SIDE_LEN      = 16,
    parameter int COLUMN_HEIGHT = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data,
    input  logic [3:0]      i_pos_x,
    input  logic [6:0]      i_pos_y,
    input  logic [3:0]      i_pos_z,
    input  logic [7:0]      i_block_value,
    input  vfcm_pkg::t_cmd  i_cmd,
    output vfcm_pkg::t_sts  o_sts,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [3:0]      o_face_x,
    output logic [6:0]      o_face_y,
    output logic [3:0]      o_face_z,
    output logic [2:0]      o_face_dir,
    output logic [1:0]      o_occl_0,
    output logic [1:0]      o_occl_1,
    output logic [1:0]      o_occl_2,
    output logic [1:0]      o_occl_3,
    output logic [7:0]      o_face_block,
    output logic            o_see_through,
    output logic            o_last_face
);
    import vfcm_pkg::*;

    localparam int DEPTH = SIDE_LEN * COLUMN_HEIGHT * SIDE_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [255:0]  r_opaque;
    logic [255:0]  r_seet;

    logic [3:0]    r_px, r_pz;
    logic [6:0]    r_py;
    logic [1:0]    r_dx, r_dy, r_dz;
    logic          r_cap_valid;
    logic [4:0]    r_cap_k;
    logic [1:0]    r_cap_src;
    logic [7:0]    r_rd_data;
    logic [26:0]   r_occ;
    logic [7:0]    r_cur;
    logic [8:0]    r_nb [6];

    logic          r_out_valid;

    logic [AW-1:0] wr_addr, rd_addr;
    int            nx, ny, nz;
    logic [1:0]    rd_src;
    logic [8:0]    cap_val;
    logic [8:0]    nb_sel;
    logic          cur_opq, nb_opq;
    logic [5:0]    vis;
    logic [1:0]    occl [4];
    logic [2:0]    occ;
    logic [5:0]    later;

    // Store write address
    assign wr_addr = AW'((int'(i_pos_x) * COLUMN_HEIGHT + int'(i_pos_y)) * SIDE_LEN
                       + int'(i_pos_z));

    // Neighbour coordinate and its source
    always_comb begin
        nx = int'(r_px) + int'(r_dx) - 1;
        ny = int'(r_py) + int'(r_dy) - 1;
        nz = int'(r_pz) + int'(r_dz) - 1;
        if (ny < 0) begin
            rd_src = SRC_SOLID;
        end else if (ny >= COLUMN_HEIGHT || nx < 0 || nx >= SIDE_LEN
                     || nz < 0 || nz >= SIDE_LEN) begin
            rd_src = SRC_AIR;
        end else begin
            rd_src = SRC_MEM;
        end
        rd_addr = AW'((nx * COLUMN_HEIGHT + ny) * SIDE_LEN + nz);
    end

    // Voxel store, one write port and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[wr_addr] <= i_block_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Mask registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opaque <= '0;
            r_seet   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OPQ0: r_opaque[63:0]    <= i_cfg_data;
                REG_OPQ1: r_opaque[127:64]  <= i_cfg_data;
                REG_OPQ2: r_opaque[191:128] <= i_cfg_data;
                REG_OPQ3: r_opaque[255:192] <= i_cfg_data;
                REG_SEE0: r_seet[63:0]      <= i_cfg_data;
                REG_SEE1: r_seet[127:64]    <= i_cfg_data;
                REG_SEE2: r_seet[191:128]   <= i_cfg_data;
                REG_SEE3: r_seet[255:192]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coordinate latch and read digit counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
            r_dx <= '0;
            r_dy <= '0;
            r_dz <= '0;
        end else if (i_cmd.rd_adv) begin
            if (r_dz == 2'd2) begin
                r_dz <= '0;
                if (r_dy == 2'd2) begin
                    r_dy <= '0;
                    r_dx <= r_dx + 2'd1;
                end else begin
                    r_dy <= r_dy + 2'd1;
                end
            end else begin
                r_dz <= r_dz + 2'd1;
            end
        end
    end

    // Track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_valid <= 1'b0;
        end else begin
            r_cap_valid <= i_cmd.rd_adv;
        end
        r_cap_k   <= 5'(r_dx * 5'd9 + r_dy * 5'd3 + 5'(r_dz));
        r_cap_src <= rd_src;
    end

    // Capture the returned neighbour
    always_comb begin
        case (r_cap_src)
            SRC_SOLID: cap_val = 9'h100;
            SRC_AIR:   cap_val = 9'h000;
            default:   cap_val = {1'b0, r_rd_data};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_cap_valid) begin
            r_occ[r_cap_k] <= (cap_val != 9'h000);
            case (r_cap_k)
                K_CENTRE: r_cur   <= cap_val[7:0];
                K_TOP:    r_nb[0] <= cap_val;
                K_BOTTOM: r_nb[1] <= cap_val;
                K_PZ:     r_nb[2] <= cap_val;
                K_MZ:     r_nb[3] <= cap_val;
                K_MX:     r_nb[4] <= cap_val;
                K_PX:     r_nb[5] <= cap_val;
                default: ;
            endcase
        end
    end

    // Culling of all six faces
    always_comb begin
        cur_opq = r_opaque[r_cur];
        for (int f = 0; f < 6; f++) begin
            nb_sel = r_nb[f];
            nb_opq = nb_sel[8] | r_opaque[nb_sel[7:0]];
            vis[f] = (r_cur != 8'd0) && ((nb_sel == 9'h000) || (cur_opq && !nb_opq)
                     || (!cur_opq && !nb_opq && nb_sel != {1'b0, r_cur}));
        end
    end

    // Corner occlusion of the current face
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int s = 0; s < 3; s++) begin
                occ[s] = r_occ[corner_slot(i_cmd.face, 2'(c), 2'(s))];
            end
            if (occ[0] && occ[1]) begin
                occl[c] = 2'd0;
            end else begin
                occl[c] = 2'(3 - int'(occ[0]) - int'(occ[1]) - int'(occ[2]));
            end
        end
        later = vis >> (i_cmd.face + 3'd1);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_face_x      <= r_px;
            o_face_y      <= r_py;
            o_face_z      <= r_pz;
            o_face_dir    <= i_cmd.face;
            o_occl_0      <= occl[0];
            o_occl_1      <= occl[1];
            o_occl_2      <= occl[2];
            o_occl_3      <= occl[3];
            o_face_block  <= r_cur;
            o_see_through <= r_seet[r_cur];
            o_last_face   <= (later == 6'd0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.rd_last  = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_sts.vis      = vis;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for voxel_face_cull_ao_mesher.
// Depends on vfcm_pkg and the RTL; a built-in predictor derives each face and its
// corner occlusion from a shadow copy of the chunk and masks, and a checker compares.
`timescale 1ns / 1ps
module tb;
    import vfcm_pkg::*;

    localparam int SIDE      = 16;
    localparam int HEIGHT    = 128;
    localparam int CYC_LIMIT = 3000000;

    // Face normals in emit order: top, bottom, +z, -z, -x, +x
    localparam int NRM [6][3] = '{
        '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1}, '{-1, 0, 0}, '{1, 0, 0}
    };
    // Per face and corner: two side voxels then the diagonal, as dx, dy, dz
    localparam int CRN [6][4][3][3] = '{
        '{ '{'{-1,1,0},'{0,1,-1},'{-1,1,-1}}, '{'{-1,1,0},'{0,1,1},'{-1,1,1}},
           '{'{1,1,0},'{0,1,1},'{1,1,1}},     '{'{1,1,0},'{0,1,-1},'{1,1,-1}} },
        '{ '{'{-1,-1,0},'{0,-1,-1},'{-1,-1,-1}}, '{'{1,-1,0},'{0,-1,-1},'{1,-1,-1}},
           '{'{1,-1,0},'{0,-1,1},'{1,-1,1}},     '{'{-1,-1,0},'{0,-1,1},'{-1,-1,1}} },
        '{ '{'{-1,0,1},'{0,-1,1},'{-1,-1,1}}, '{'{1,0,1},'{0,-1,1},'{1,-1,1}},
           '{'{1,0,1},'{0,1,1},'{1,1,1}},     '{'{-1,0,1},'{0,1,1},'{-1,1,1}} },
        '{ '{'{1,0,-1},'{0,-1,-1},'{1,-1,-1}}, '{'{-1,0,-1},'{0,-1,-1},'{-1,-1,-1}},
           '{'{-1,0,-1},'{0,1,-1},'{-1,1,-1}}, '{'{1,0,-1},'{0,1,-1},'{1,1,-1}} },
        '{ '{'{-1,-1,0},'{-1,0,-1},'{-1,-1,-1}}, '{'{-1,-1,0},'{-1,0,1},'{-1,-1,1}},
           '{'{-1,1,0},'{-1,0,1},'{-1,1,1}},     '{'{-1,1,0},'{-1,0,-1},'{-1,1,-1}} },
        '{ '{'{1,-1,0},'{1,0,1},'{1,-1,1}},  '{'{1,-1,0},'{1,0,-1},'{1,-1,-1}},
           '{'{1,1,0},'{1,0,-1},'{1,1,-1}},  '{'{1,1,0},'{1,0,1},'{1,1,1}} }
    };

    typedef struct {
        logic [3:0] x;
        logic [6:0] y;
        logic [3:0] z;
        logic [2:0] dir;
        logic [1:0] occl [4];
        logic [7:0] blk;
        logic       see;
        logic       last;
    } t_face;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = ACT_STORE;
    logic [3:0]  i_pos_x = '0;
    logic [6:0]  i_pos_y = '0;
    logic [3:0]  i_pos_z = '0;
    logic [7:0]  i_block_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_face_x;
    logic [6:0]  o_face_y;
    logic [3:0]  o_face_z;
    logic [2:0]  o_face_dir;
    logic [1:0]  o_occl_0, o_occl_1, o_occl_2, o_occl_3;
    logic [7:0]  o_face_block;
    logic        o_see_through;
    logic        o_last_face;

    // Shadow chunk, written flags and mask registers
    logic [7:0]  chunk [SIDE*HEIGHT*SIDE];
    bit          stored [SIDE*HEIGHT*SIDE];
    logic [63:0] opq_mask [4];
    logic [63:0] see_mask [4];

    t_face       face_q [$];
    int          mismatches = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          hold_cycles = 0;
    int          cycles = 0;

    voxel_face_cull_ao_mesher dut (.*);

    always #10 i_clk = ~i_clk;

    // Chunk id at a coordinate; bit 8 marks the solid below the world
    function automatic logic [8:0] chunk_at(int x, int y, int z);
        if (y < 0) return 9'h100;
        if (y >= HEIGHT || x < 0 || x >= SIDE || z < 0 || z >= SIDE) return 9'h000;
        return {1'b0, chunk[(x*HEIGHT + y)*SIDE + z]};
    endfunction

    function automatic bit opaque(logic [8:0] v);
        if (v[8]) return 1'b1;
        return opq_mask[v[7:6]][v[5:0]];
    endfunction

    function automatic bit shows(logic [8:0] cur, logic [8:0] nb);
        bit co, no;
        co = opaque(cur);
        no = opaque(nb);
        if (nb == 0) return 1'b1;
        if (co && !no) return 1'b1;
        return !co && !no && cur != nb;
    endfunction

    // Queue the visible faces of one meshed voxel
    task automatic mesh_faces(int x, int y, int z);
        logic [8:0] cur;
        t_face      fc;
        bit         occ [3];
        int         n;
        cur = chunk_at(x, y, z);
        n = 0;
        if (cur == 0) return;
        for (int f = 0; f < 6; f++) begin
            if (!shows(cur, chunk_at(x + NRM[f][0], y + NRM[f][1], z + NRM[f][2])))
                continue;
            fc.x = 4'(x); fc.y = 7'(y); fc.z = 4'(z); fc.dir = 3'(f);
            for (int k = 0; k < 4; k++) begin
                for (int s = 0; s < 3; s++)
                    occ[s] = chunk_at(x + CRN[f][k][s][0], y + CRN[f][k][s][1],
                                      z + CRN[f][k][s][2]) != 0;
                fc.occl[k] = (occ[0] && occ[1]) ? 2'd0 :
                             2'(3 - int'(occ[0]) - int'(occ[1]) - int'(occ[2]));
            end
            fc.blk = cur[7:0];
            fc.see = see_mask[cur[7:6]][cur[5:0]];
            fc.last = 1'b0;
            face_q.push_back(fc);
            n++;
        end
        if (n > 0) face_q[face_q.size()-1].last = 1'b1;
    endtask

    // Offer one transaction and predict once accepted; valid stays high on return
    task automatic send_item(logic act, int x, int y, int z, logic [7:0] v);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_pos_x <= 4'(x);
        i_pos_y <= 7'(y);
        i_pos_z <= 4'(z);
        i_block_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (act == ACT_STORE) begin
            chunk[(x*HEIGHT + y)*SIDE + z] = v;
            stored[(x*HEIGHT + y)*SIDE + z] = 1'b1;
        end else begin
            mesh_faces(x, y, z);
        end
    endtask

    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'd0;
        if (r < 80) begin
            case ($urandom_range(4))
                0: return 8'd1;
                1: return 8'd2;
                2: return 8'd70;
                3: return 8'd200;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom);
    endfunction

    // Fill any unwritten neighbour first, then mesh the voxel
    task automatic mesh_at(int x, int y, int z);
        for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dz = -1; dz <= 1; dz++)
                    if (x+dx >= 0 && x+dx < SIDE && y+dy >= 0 && y+dy < HEIGHT &&
                        z+dz >= 0 && z+dz < SIDE &&
                        !stored[((x+dx)*HEIGHT + y+dy)*SIDE + z+dz])
                        send_item(ACT_STORE, x+dx, y+dy, z+dz, pick_id());
        send_item(ACT_MESH, x, y, z, 8'($urandom));
    endtask

    // Drop valid and wait until every face is back and the block has settled
    task automatic wait_idle();
        i_valid <= 1'b0;
        wait (face_q.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx < REG_SEE0) opq_mask[idx[1:0]] = data;
        else if (idx <= REG_SEE3) see_mask[idx[1:0]] = data;
        @(posedge i_clk);
    endtask

    task automatic load_masks(logic [63:0] o0, logic [63:0] o1, logic [63:0] o2,
                              logic [63:0] o3, logic [63:0] s0, logic [63:0] s1,
                              logic [63:0] s2, logic [63:0] s3);
        write_reg(REG_OPQ0, o0);
        write_reg(REG_OPQ1, o1);
        write_reg(REG_OPQ2, o2);
        write_reg(REG_OPQ3, o3);
        write_reg(REG_SEE0, s0);
        write_reg(REG_SEE1, s1);
        write_reg(REG_SEE2, s2);
        write_reg(REG_SEE3, s3);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_random_masks();
        load_masks(rand64(), rand64(), rand64(), rand64(),
                   rand64(), rand64(), rand64(), rand64());
    endtask

    // Extreme masks, writes to unused indexes that must change nothing, then one mesh
    task automatic test_registers();
        load_masks('1, '1, '1, '1, '1, '1, '1, '1);
        load_masks('0, '0, '0, '0, '0, '0, '0, '0);
        for (int i = 8; i < 16; i++) write_reg(4'(i), rand64());
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_item(ACT_STORE, 8, 64, 8, 8'd5);
        mesh_at(8, 64, 8);
        wait_idle();
    endtask

    // Chunk edges, world floor and ceiling, air and extreme ids
    task automatic test_edges();
        load_masks(64'h5555_5555_5555_5555, '0, '1, 64'h8000_0000_0000_0000,
                   64'h0000_0000_0000_0006, '0, '0, '1);
        send_item(ACT_STORE, 0, 0, 0, 8'd255);
        mesh_at(0, 0, 0);
        send_item(ACT_STORE, 15, 127, 15, 8'd1);
        mesh_at(15, 127, 15);
        send_item(ACT_STORE, 15, 0, 0, 8'd2);
        mesh_at(15, 0, 0);
        send_item(ACT_STORE, 0, 127, 15, 8'd128);
        mesh_at(0, 127, 15);
        send_item(ACT_STORE, 7, 1, 9, 8'd0);
        mesh_at(7, 1, 9);
        send_item(ACT_STORE, 7, 2, 9, 8'd2);
        send_item(ACT_STORE, 7, 3, 9, 8'd2);
        mesh_at(7, 2, 9);
        send_item(ACT_STORE, 7, 3, 9, 8'd1);
        mesh_at(7, 2, 9);
        mesh_at(7, 0, 9);
        wait_idle();
    endtask

    // Stores and meshes inside a small busy region, stray stores anywhere in the chunk
    task automatic test_random(int count, int tx_pct, int rx_pct);
        int x, y, z;
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        load_random_masks();
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15) begin
                x = $urandom_range(SIDE-1);
                y = $urandom_range(HEIGHT-1);
                z = $urandom_range(SIDE-1);
                send_item(ACT_STORE, x, y, z, pick_id());
            end else begin
                x = $urandom_range(4, 5);
                y = $urandom_range(0, 1);
                z = $urandom_range(10, 11);
                if ($urandom_range(99) < 45) send_item(ACT_STORE, x, y, z, pick_id());
                else mesh_at(x, y, z);
            end
        end
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering meshes
    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        load_masks('0, '0, '0, '0, '0, '0, '0, '0);
        hold_cycles = 600;
        for (int i = 0; i < 12; i++)
            mesh_at($urandom_range(4, 5), $urandom_range(0, 1), $urandom_range(10, 11));
        wait_idle();
    endtask

    // Receiver ready, with a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Compare each accepted face with the oldest prediction
    always @(posedge i_clk) begin
        t_face e;
        if (i_rst_n && o_valid && i_ready) begin
            if (face_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected face at %0d,%0d,%0d dir %0d",
                             o_face_x, o_face_y, o_face_z, o_face_dir);
            end else begin
                e = face_q.pop_front();
                if (o_face_x !== e.x || o_face_y !== e.y || o_face_z !== e.z ||
                    o_face_dir !== e.dir || o_occl_0 !== e.occl[0] ||
                    o_occl_1 !== e.occl[1] || o_occl_2 !== e.occl[2] ||
                    o_occl_3 !== e.occl[3] || o_face_block !== e.blk ||
                    o_see_through !== e.see || o_last_face !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("face mismatch exp %0d,%0d,%0d d%0d ao %0d%0d%0d%0d ",
                               e.x, e.y, e.z, e.dir, e.occl[0], e.occl[1],
                               e.occl[2], e.occl[3]);
                        $write("b%0d s%0d l%0d ", e.blk, e.see, e.last);
                        $write("got %0d,%0d,%0d d%0d ao %0d%0d%0d%0d ",
                               o_face_x, o_face_y, o_face_z, o_face_dir,
                               o_occl_0, o_occl_1, o_occl_2, o_occl_3);
                        $display("b%0d s%0d l%0d", o_face_block, o_see_through,
                                 o_last_face);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) begin
            opq_mask[i] = '0;
            see_mask[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        test_edges();
        test_random(35, 36, 53);
        test_random(35, 53, 36);
        test_random(35, 0, 0);
        test_backpressure();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
